// File: src/epr_pkg.sv
// ----------------------------------------------------------------------------
// epr_pkg
// shared sizes, codes and command types for the effect pool room list manager
// ----------------------------------------------------------------------------
package epr_pkg;

    localparam int SLOTS = 64;
    localparam int ROOMS = 256;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = SW + 1;
    localparam int RW = (ROOMS > 1) ? $clog2(ROOMS) : 1;

    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int ROOM_W  = 8;
    localparam int STAT_W  = 2;

    localparam logic [LW-1:0] NONE_LINK = LW'(SLOTS);

    typedef enum logic [KIND_W-1:0] {
        K_CREATE = 2'd0,
        K_KILL   = 2'd1,
        K_MOVE   = 2'd2,
        K_BAD    = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOT_LIVE = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_C_READ,
        OP_C_WRITE,
        OP_S_READ,
        OP_CAP_KILL,
        OP_CAP_MOVE,
        OP_A_STEP,
        OP_R_HEAD_READ,
        OP_R_HEAD_STEP,
        OP_R_STEP,
        OP_K_FIN,
        OP_M_READ,
        OP_M_WRITE
    } t_dp_op;

    typedef struct packed {
        logic is_create;
        logic is_kill;
        logic fail;
        logic a_head_done;
        logic a_stop;
        logic r_head_stop;
        logic r_stop;
    } t_dp_stat;

endpackage

// File: src/epr_ctrl.sv
// ----------------------------------------------------------------------------
// epr_ctrl
// sequencer that steps the datapath through create, kill and move
// ----------------------------------------------------------------------------
module epr_ctrl
    import epr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op,
    output logic     busy,
    output logic     o_valid
);

    typedef enum logic [13:0] {
        S_IDLE         = 14'b00000000000001,
        S_DISPATCH     = 14'b00000000000010,
        S_C_READ       = 14'b00000000000100,
        S_C_WRITE      = 14'b00000000001000,
        S_S_READ       = 14'b00000000010000,
        S_CAPTURE      = 14'b00000000100000,
        S_A_STEP       = 14'b00000001000000,
        S_R_HEAD_READ  = 14'b00000010000000,
        S_R_HEAD_STEP  = 14'b00000100000000,
        S_R_STEP       = 14'b00001000000000,
        S_K_FIN        = 14'b00010000000000,
        S_M_READ       = 14'b00100000000000,
        S_M_WRITE      = 14'b01000000000000,
        S_DONE         = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state after_room;

    assign after_room = i_stat.is_kill ? S_K_FIN : S_M_READ;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_op    = OP_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.fail) begin
                    n_state = S_DONE;
                end else if (i_stat.is_create) begin
                    n_state = S_C_READ;
                end else begin
                    n_state = S_S_READ;
                end
            end
            S_C_READ: begin
                o_op    = OP_C_READ;
                n_state = S_C_WRITE;
            end
            S_C_WRITE: begin
                o_op    = OP_C_WRITE;
                n_state = S_DONE;
            end
            S_S_READ: begin
                o_op    = OP_S_READ;
                n_state = S_CAPTURE;
            end
            S_CAPTURE: begin
                if (i_stat.is_kill) begin
                    o_op    = OP_CAP_KILL;
                    n_state = i_stat.a_head_done ? S_R_HEAD_READ : S_A_STEP;
                end else begin
                    o_op    = OP_CAP_MOVE;
                    n_state = S_R_HEAD_READ;
                end
            end
            S_A_STEP: begin
                o_op = OP_A_STEP;
                if (i_stat.a_stop) begin
                    n_state = S_R_HEAD_READ;
                end
            end
            S_R_HEAD_READ: begin
                o_op    = OP_R_HEAD_READ;
                n_state = S_R_HEAD_STEP;
            end
            S_R_HEAD_STEP: begin
                o_op    = OP_R_HEAD_STEP;
                n_state = i_stat.r_head_stop ? after_room : S_R_STEP;
            end
            S_R_STEP: begin
                o_op = OP_R_STEP;
                if (i_stat.r_stop) begin
                    n_state = after_room;
                end
            end
            S_K_FIN: begin
                o_op    = OP_K_FIN;
                n_state = S_DONE;
            end
            S_M_READ: begin
                o_op    = OP_M_READ;
                n_state = S_M_WRITE;
            end
            S_M_WRITE: begin
                o_op    = OP_M_WRITE;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// File: src/epr_dpath.sv
// ----------------------------------------------------------------------------
// epr_dpath
// list heads, link memories, live bits and the request and result registers
// ----------------------------------------------------------------------------
module epr_dpath
    import epr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_op            i_op,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SLOT_W-1:0] i_slot_index,
    input  logic [ROOM_W-1:0] i_room_id,
    output t_dp_stat          o_stat,
    output logic [SLOT_W-1:0] o_granted_slot,
    output logic [STAT_W-1:0] o_status
);

    // link memories and room heads
    logic [LW-1:0] m_room_head [ROOMS];
    logic [LW-1:0] m_room_link [SLOTS];
    logic [LW-1:0] m_act_link  [SLOTS];
    logic [RW-1:0] m_slot_room [SLOTS];

    logic [ROOMS-1:0] r_rh_vld;
    logic [SLOTS-1:0] r_rl_vld;
    logic [SLOTS-1:0] r_live;

    logic [LW-1:0]     r_free_head, n_free_head;
    logic [LW-1:0]     r_act_head,  n_act_head;
    logic [KIND_W-1:0] r_kind,      n_kind;
    logic [LW-1:0]     r_slot,      n_slot;
    logic [RW-1:0]     r_room,      n_room;
    logic [RW-1:0]     r_old_room,  n_old_room;
    logic [LW-1:0]     r_cur,       n_cur;
    logic [LW-1:0]     r_a_next,    n_a_next;
    logic [LW-1:0]     r_r_next,    n_r_next;
    logic [SLOT_W-1:0] r_grant,     n_grant;
    t_status           r_status,    n_status;

    // registered read data
    logic [LW-1:0] r_rh_rd;
    logic          r_rh_rd_vld;
    logic [LW-1:0] r_rl_rd;
    logic          r_rl_rd_vld;
    logic [SW-1:0] r_rl_rd_addr;
    logic [LW-1:0] r_act_rd;
    logic [RW-1:0] r_sr_rd;

    logic [LW-1:0] rh_out;
    logic [LW-1:0] rl_out;

    // port controls
    logic [RW-1:0] rh_raddr, rh_waddr;
    logic [LW-1:0] rh_wdata;
    logic          rh_we;
    logic [SW-1:0] rl_raddr, rl_waddr;
    logic [LW-1:0] rl_wdata;
    logic          rl_we;
    logic [SW-1:0] act_raddr, act_waddr;
    logic [LW-1:0] act_wdata;
    logic          act_we;
    logic [SW-1:0] sr_raddr;
    logic          sr_we;
    logic          live_set, live_clr;
    logic [SW-1:0] live_addr;

    logic [LW-1:0] in_slot;
    logic          in_live;

    assign rh_out = r_rh_rd_vld ? r_rh_rd : NONE_LINK;
    assign rl_out = r_rl_rd_vld ? r_rl_rd : (LW'(r_rl_rd_addr) + LW'(1));

    assign in_slot = LW'(i_slot_index);
    assign in_live = (in_slot < LW'(SLOTS)) && r_live[in_slot[SW-1:0]];

    always_comb begin
        n_free_head = r_free_head;
        n_act_head  = r_act_head;
        n_kind      = r_kind;
        n_slot      = r_slot;
        n_room      = r_room;
        n_old_room  = r_old_room;
        n_cur       = r_cur;
        n_a_next    = r_a_next;
        n_r_next    = r_r_next;
        n_grant     = r_grant;
        n_status    = r_status;
        rh_raddr    = r_room;
        rh_waddr    = r_room;
        rh_wdata    = r_slot;
        rh_we       = 1'b0;
        rl_raddr    = r_slot[SW-1:0];
        rl_waddr    = r_slot[SW-1:0];
        rl_wdata    = r_r_next;
        rl_we       = 1'b0;
        act_raddr   = r_slot[SW-1:0];
        act_waddr   = r_cur[SW-1:0];
        act_wdata   = r_a_next;
        act_we      = 1'b0;
        sr_raddr    = r_slot[SW-1:0];
        sr_we       = 1'b0;
        live_set    = 1'b0;
        live_clr    = 1'b0;
        live_addr   = r_slot[SW-1:0];
        unique case (i_op)
            OP_LOAD: begin
                n_kind  = i_kind;
                n_slot  = in_slot;
                n_room  = RW'(32'(i_room_id) % ROOMS);
                n_grant = i_slot_index;
                if (i_kind == K_BAD || (i_kind != K_CREATE && !in_live)) begin
                    n_status = ST_NOT_LIVE;
                end else if (i_kind == K_CREATE && r_free_head == NONE_LINK) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = ST_OK;
                end
            end
            OP_C_READ: begin
                rl_raddr = r_free_head[SW-1:0];
                rh_raddr = r_room;
            end
            OP_C_WRITE: begin
                n_free_head = rl_out;
                rl_waddr    = r_free_head[SW-1:0];
                rl_wdata    = rh_out;
                rl_we       = 1'b1;
                rh_waddr    = r_room;
                rh_wdata    = r_free_head;
                rh_we       = 1'b1;
                sr_we       = 1'b1;
                act_waddr   = r_free_head[SW-1:0];
                act_wdata   = r_act_head;
                act_we      = 1'b1;
                n_act_head  = r_free_head;
                live_addr   = r_free_head[SW-1:0];
                live_set    = 1'b1;
                n_grant     = SLOT_W'(r_free_head[SW-1:0]);
            end
            OP_S_READ: begin
                act_raddr = r_slot[SW-1:0];
                rl_raddr  = r_slot[SW-1:0];
                sr_raddr  = r_slot[SW-1:0];
            end
            OP_CAP_KILL: begin
                n_a_next   = r_act_rd;
                n_r_next   = rl_out;
                n_old_room = r_sr_rd;
                if (r_act_head == r_slot) begin
                    n_act_head = r_act_rd;
                end else if (r_act_head != NONE_LINK) begin
                    n_cur     = r_act_head;
                    act_raddr = r_act_head[SW-1:0];
                end
            end
            OP_CAP_MOVE: begin
                n_a_next   = r_act_rd;
                n_r_next   = rl_out;
                n_old_room = r_sr_rd;
            end
            OP_A_STEP: begin
                if (r_act_rd == r_slot) begin
                    act_waddr = r_cur[SW-1:0];
                    act_wdata = r_a_next;
                    act_we    = 1'b1;
                end else if (r_act_rd != NONE_LINK) begin
                    n_cur     = r_act_rd;
                    act_raddr = r_act_rd[SW-1:0];
                end
            end
            OP_R_HEAD_READ: begin
                rh_raddr = r_old_room;
            end
            OP_R_HEAD_STEP: begin
                if (rh_out == r_slot) begin
                    rh_waddr = r_old_room;
                    rh_wdata = r_r_next;
                    rh_we    = 1'b1;
                end else if (rh_out != NONE_LINK) begin
                    n_cur    = rh_out;
                    rl_raddr = rh_out[SW-1:0];
                end
            end
            OP_R_STEP: begin
                if (rl_out == r_slot) begin
                    rl_waddr = r_cur[SW-1:0];
                    rl_wdata = r_r_next;
                    rl_we    = 1'b1;
                end else if (rl_out != NONE_LINK) begin
                    n_cur    = rl_out;
                    rl_raddr = rl_out[SW-1:0];
                end
            end
            OP_K_FIN: begin
                rl_waddr    = r_slot[SW-1:0];
                rl_wdata    = r_free_head;
                rl_we       = 1'b1;
                n_free_head = r_slot;
                live_clr    = 1'b1;
            end
            OP_M_READ: begin
                rh_raddr = r_room;
            end
            OP_M_WRITE: begin
                sr_we    = 1'b1;
                rl_waddr = r_slot[SW-1:0];
                rl_wdata = rh_out;
                rl_we    = 1'b1;
                rh_waddr = r_room;
                rh_wdata = r_slot;
                rh_we    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (rh_we) begin
            m_room_head[rh_waddr] <= rh_wdata;
        end
        r_rh_rd <= m_room_head[rh_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rl_we) begin
            m_room_link[rl_waddr] <= rl_wdata;
        end
        r_rl_rd      <= m_room_link[rl_raddr];
        r_rl_rd_addr <= rl_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (act_we) begin
            m_act_link[act_waddr] <= act_wdata;
        end
        r_act_rd <= m_act_link[act_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sr_we) begin
            m_slot_room[live_addr] <= r_room;
        end
        r_sr_rd <= m_slot_room[sr_raddr];
    end

    // valid and live bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rh_vld    <= '0;
            r_rl_vld    <= '0;
            r_live      <= '0;
            r_rh_rd_vld <= 1'b0;
            r_rl_rd_vld <= 1'b0;
            r_free_head <= '0;
            r_act_head  <= NONE_LINK;
        end else begin
            r_rh_rd_vld <= r_rh_vld[rh_raddr];
            r_rl_rd_vld <= r_rl_vld[rl_raddr];
            if (rh_we) begin
                r_rh_vld[rh_waddr] <= 1'b1;
            end
            if (rl_we) begin
                r_rl_vld[rl_waddr] <= 1'b1;
            end
            if (live_set) begin
                r_live[live_addr] <= 1'b1;
            end else if (live_clr) begin
                r_live[live_addr] <= 1'b0;
            end
            r_free_head <= n_free_head;
            r_act_head  <= n_act_head;
        end
    end

    // request and result registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_slot     <= n_slot;
        r_room     <= n_room;
        r_old_room <= n_old_room;
        r_cur      <= n_cur;
        r_a_next   <= n_a_next;
        r_r_next   <= n_r_next;
        r_grant    <= n_grant;
        r_status   <= n_status;
    end

    assign o_stat.is_create   = (r_kind == K_CREATE);
    assign o_stat.is_kill     = (r_kind == K_KILL);
    assign o_stat.fail        = (r_status != ST_OK);
    assign o_stat.a_head_done = (r_act_head == r_slot) || (r_act_head == NONE_LINK);
    assign o_stat.a_stop      = (r_act_rd == r_slot) || (r_act_rd == NONE_LINK);
    assign o_stat.r_head_stop = (rh_out == r_slot) || (rh_out == NONE_LINK);
    assign o_stat.r_stop      = (rl_out == r_slot) || (rl_out == NONE_LINK);

    assign o_granted_slot = r_grant;
    assign o_status       = r_status;

endmodule

// File: src/effect_pool_room_list_manager.sv
// ----------------------------------------------------------------------------
// effect_pool_room_list_manager
// slot pool with free, active and per-room linked lists
// ----------------------------------------------------------------------------
//  channel   ports                                   beat taken when
//  request   i_kind, i_slot_index, i_room_id         start high and busy low
//  result    o_granted_slot, o_status                o_valid high
//
//  create raises the result strobe after the dispatch, free read and free
//  write states, a failed request straight after dispatch
//  kill walks the active list then the room list, one link a cycle through
//  the link memory read ports, before the strobe
//  move walks the room list only
//  busy drops the cycle after the result beat, the receiver cannot stall
//  synchronous active-low reset, no clearing pass (valid bits per entry)
// ----------------------------------------------------------------------------
module effect_pool_room_list_manager
    import epr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SLOT_W-1:0] i_slot_index,
    input  logic [ROOM_W-1:0] i_room_id,
    output logic              o_valid,
    output logic [SLOT_W-1:0] o_granted_slot,
    output logic [STAT_W-1:0] o_status
);

    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    epr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .o_op    (dp_op),
        .busy    (busy),
        .o_valid (o_valid)
    );

    epr_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (dp_op),
        .i_kind         (i_kind),
        .i_slot_index   (i_slot_index),
        .i_room_id      (i_room_id),
        .o_stat         (dp_stat),
        .o_granted_slot (o_granted_slot),
        .o_status       (o_status)
    );

endmodule

// File: tb/tb_effect_pool_room_list_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_effect_pool_room_list_manager
// self-checking bench for the effect slot pool and its room lists
//
// a behavioral copy of the pool (free, active and room lists plus live bits)
// predicts the granted slot and status of each accepted request beat. results
// are checked in order against that prediction. directed requests hit the
// error codes and list edge cases, then the pool is filled to exhaustion and
// emptied, then long random traffic crowds a few rooms so the list walks run
// deep. after the directed requests the request side idles at random between beats.
// ----------------------------------------------------------------------------
module tb_effect_pool_room_list_manager;
    import epr_pkg::*;

    localparam int DRAIN_CYCLES = 2 * SLOTS + 20;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_BEATS = 620;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_grant;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [KIND_W-1:0] i_kind = '0;
    logic [SLOT_W-1:0] i_slot_index = '0;
    logic [ROOM_W-1:0] i_room_id = '0;
    logic              o_valid;
    logic [SLOT_W-1:0] o_granted_slot;
    logic [STAT_W-1:0] o_status;

    // shadow copy of the pool
    logic [LW-1:0] free_top;
    logic [LW-1:0] active_top;
    logic [LW-1:0] room_top [ROOMS];
    logic [LW-1:0] room_next [SLOTS];
    logic [LW-1:0] active_next [SLOTS];
    logic [RW-1:0] home_room [SLOTS];
    bit            slot_alive [SLOTS];

    t_grant expected_grants [$];
    int     mismatch_count = 0;
    int     gap_style = 0;

    effect_pool_room_list_manager u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_slot_index   (i_slot_index),
        .i_room_id      (i_room_id),
        .o_valid        (o_valid),
        .o_granted_slot (o_granted_slot),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void pool_reset();
        free_top   = '0;
        active_top = NONE_LINK;
        for (int i = 0; i < ROOMS; i++)
            room_top[i] = NONE_LINK;
        for (int i = 0; i < SLOTS; i++) begin
            room_next[i]   = LW'(i + 1);
            active_next[i] = '0;
            home_room[i]   = '0;
            slot_alive[i]  = 1'b0;
        end
        room_next[SLOTS-1] = NONE_LINK;
    endfunction

    function automatic void room_insert(input logic [RW-1:0] rm, input logic [SW-1:0] s);
        home_room[s] = rm;
        room_next[s] = room_top[rm];
        room_top[rm] = LW'(s);
    endfunction

    function automatic void room_remove(input logic [RW-1:0] rm, input logic [SW-1:0] s);
        logic [LW-1:0] cur;
        cur = room_top[rm];
        if (cur == LW'(s)) begin
            room_top[rm] = room_next[s];
            return;
        end
        for (int n = 0; n < SLOTS && cur < NONE_LINK; n++) begin
            if (room_next[cur[SW-1:0]] == LW'(s)) begin
                room_next[cur[SW-1:0]] = room_next[s];
                return;
            end
            cur = room_next[cur[SW-1:0]];
        end
    endfunction

    function automatic void pool_apply(
        input  t_kind             k,
        input  logic [SLOT_W-1:0] s,
        input  logic [ROOM_W-1:0] r,
        output logic [SLOT_W-1:0] g,
        output t_status           st
    );
        logic [LW-1:0] f;
        logic [LW-1:0] cur;
        logic [RW-1:0] rm;
        logic          alive;
        rm    = RW'(32'(r) % ROOMS);
        g     = s;
        st    = ST_OK;
        alive = (int'(s) < SLOTS) && slot_alive[s];
        case (k)
            K_CREATE: begin
                f = free_top;
                if (f >= NONE_LINK) begin
                    st = ST_EMPTY;
                end else begin
                    free_top = room_next[f[SW-1:0]];
                    room_insert(rm, f[SW-1:0]);
                    active_next[f[SW-1:0]] = active_top;
                    active_top = f;
                    slot_alive[f[SW-1:0]] = 1'b1;
                    g = f[SW-1:0];
                end
            end
            K_KILL: begin
                if (!alive) begin
                    st = ST_NOT_LIVE;
                end else begin
                    cur = active_top;
                    if (cur == LW'(s)) begin
                        active_top = active_next[s];
                    end else begin
                        for (int n = 0; n < SLOTS && cur < NONE_LINK; n++) begin
                            if (active_next[cur[SW-1:0]] == LW'(s)) begin
                                active_next[cur[SW-1:0]] = active_next[s];
                                break;
                            end
                            cur = active_next[cur[SW-1:0]];
                        end
                    end
                    room_remove(home_room[s], s);
                    room_next[s]  = free_top;
                    free_top      = LW'(s);
                    slot_alive[s] = 1'b0;
                end
            end
            K_MOVE: begin
                if (!alive) begin
                    st = ST_NOT_LIVE;
                end else begin
                    room_remove(home_room[s], s);
                    room_insert(rm, s);
                end
            end
            default: st = ST_NOT_LIVE;
        endcase
    endfunction

    function automatic logic [LW-1:0] pick_live_slot();
        int base;
        int idx;
        base = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < SLOTS; i++) begin
            idx = (base + i) % SLOTS;
            if (slot_alive[idx])
                return LW'(idx);
        end
        return NONE_LINK;
    endfunction

    function automatic int gap_len();
        int roll;
        if (gap_style == 0)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ROOM_W-1:0] pick_room();
        if ($urandom_range(0, 99) < 75)
            return ROOM_W'($urandom_range(0, 3));
        return ROOM_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(
        input t_kind             k,
        input logic [SLOT_W-1:0] s,
        input logic [ROOM_W-1:0] r
    );
        int                gap;
        logic [SLOT_W-1:0] g;
        t_status           st;
        t_grant            beat_want;
        gap = gap_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind       <= k;
        i_slot_index <= s;
        i_room_id    <= r;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        pool_apply(k, s, r, g, st);
        beat_want.slot   = g;
        beat_want.status = st;
        expected_grants.insert(expected_grants.size(), beat_want);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed_cases();
        gap_style = 0;
        send_beat(K_KILL, 6'd0, 8'd0);
        send_beat(K_MOVE, 6'd63, 8'd255);
        send_beat(K_BAD, 6'd63, 8'd255);
        send_beat(K_BAD, 6'd0, 8'd0);
        send_beat(K_CREATE, 6'd63, 8'd0);
        send_beat(K_CREATE, 6'd0, 8'd255);
        send_beat(K_CREATE, 6'd21, 8'd0);
        send_beat(K_CREATE, 6'd42, 8'd0);
        // same room: unlink and push back at the head
        send_beat(K_MOVE, 6'd2, 8'd0);
        send_beat(K_MOVE, 6'd0, 8'd255);
        send_beat(K_MOVE, 6'd1, 8'd0);
        send_beat(K_KILL, 6'd3, 8'd0);
        send_beat(K_KILL, 6'd0, 8'd170);
        send_beat(K_KILL, 6'd0, 8'd85);
        send_beat(K_KILL, 6'd1, 8'd0);
        send_beat(K_CREATE, 6'd0, 8'd128);
        send_beat(K_MOVE, 6'd5, 8'd1);
        send_beat(K_KILL, 6'd2, 8'd0);
        send_beat(K_CREATE, 6'd0, 8'd0);
        drain_results();
    endtask

    task automatic test_fill_and_empty();
        logic [LW-1:0] s;
        gap_style = 1;
        s = pick_live_slot();
        while (s != NONE_LINK) begin
            send_beat(K_KILL, s[SW-1:0], pick_room());
            s = pick_live_slot();
        end
        repeat (SLOTS + 3)
            send_beat(K_CREATE, SLOT_W'($urandom_range(0, 63)), pick_room());
        repeat (12) begin
            s = pick_live_slot();
            send_beat(K_MOVE, s[SW-1:0], pick_room());
        end
        s = pick_live_slot();
        while (s != NONE_LINK) begin
            send_beat(K_KILL, s[SW-1:0], ROOM_W'($urandom_range(0, 255)));
            s = pick_live_slot();
        end
        send_beat(K_KILL, SLOT_W'($urandom_range(0, 63)), 8'd0);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int            roll;
        int            create_w;
        int            kill_w;
        logic [LW-1:0] s;
        t_kind         k;
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            gap_style = ((i / 100) % 3 != 0);
            create_w  = ((i / 150) % 2 == 0) ? 45 : 20;
            kill_w    = 65 - create_w;
            roll      = $urandom_range(0, 99);
            if (roll < create_w) begin
                send_beat(K_CREATE, SLOT_W'($urandom_range(0, 63)), pick_room());
            end else if (roll < 92) begin
                k = (roll < create_w + kill_w) ? K_KILL : K_MOVE;
                s = pick_live_slot();
                if (s == NONE_LINK)
                    s = LW'($urandom_range(0, SLOTS - 1));
                send_beat(k, s[SW-1:0], pick_room());
            end else begin
                // error traffic: bad kind or a slot that is most likely free
                k = t_kind'($urandom_range(1, 3));
                send_beat(k, SLOT_W'($urandom_range(0, 63)), ROOM_W'($urandom_range(0, 255)));
            end
        end
        drain_results();
    endtask

    always @(posedge i_clk) begin : result_check
        t_grant want;
        if (i_rst_n && o_valid) begin
            if (expected_grants.size() == 0) begin
                report_mismatch($sformatf("unexpected result slot %0d status %0d",
                                          o_granted_slot, o_status));
            end else begin
                want = expected_grants.pop_front();
                if (o_granted_slot !== want.slot)
                    report_mismatch($sformatf("granted slot expected %0d actual %0d",
                                              want.slot, o_granted_slot));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status expected %0d actual %0d",
                                              want.status, o_status));
            end
        end
    end

    initial begin
        pool_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_cases();
        test_fill_and_empty();
        test_random_traffic();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
